FILE: src/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg: shared types and constants for the two-button press classifier
// Transaction payloads, per-button state, action flags and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpc_pkg;

  localparam int unsigned HoldW = 10;
  localparam int unsigned RelW  = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE    = 1'd1;

  localparam logic [HoldW-1:0] LongPressReset = 10'd50;
  localparam logic [RelW-1:0]  ReleaseReset   = 8'd2;

  // op codes
  localparam logic [1:0] OP_ONE_EDGE = 2'd0;
  localparam logic [1:0] OP_TWO_EDGE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       one_down;
    logic       two_down;
    logic       alarm_active;
    logic       settings_active;
  } in_item_t;

  typedef struct packed {
    logic start_feedback;
    logic ack_alarm;
    logic enter_settings;
    logic exit_settings;
    logic select_option;
    logic next_option;
    logic refresh_display;
    logic unit_is_fahrenheit;
    logic wake;
    logic idle;
  } out_item_t;

  typedef struct packed {
    logic             busy;
    logic [HoldW-1:0] hold;
    logic [RelW-1:0]  rel;
    logic             long_done;
    logic             consumed;
  } btn_state_t;

  typedef struct packed {
    logic feedback;
    logic ack;
    logic enter;
    logic exitm;
    logic select;
    logic next;
    logic refresh;
    logic wake;
    logic toggle;
  } acts_t;

  // flags passed along the button chain within one tick
  typedef struct packed {
    logic alarm;
    logic settings;
  } flags_t;

endpackage

`default_nettype wire

FILE: src/tbpc_button.sv
// ----------------------------------------------------------------------------
// tbpc_button: arm and tick logic for one button
// Combinational next state and action flags for one button per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpc_button import tbpc_pkg::*; (
  input  logic             is_one_i,
  input  logic             edge_i,
  input  logic             tick_i,
  input  logic             down_i,
  input  logic             other_down_i,
  input  logic             alarm_edge_i,
  input  flags_t           flags_i,
  input  logic [HoldW-1:0] long_press_i,
  input  logic [RelW-1:0]  release_i,
  input  btn_state_t       state_i,
  output btn_state_t       state_o,
  output flags_t           flags_o,
  output acts_t            acts_o
);

  logic [HoldW-1:0] hold_inc;
  logic [RelW-1:0]  rel_inc;

  always_comb begin
    state_o  = state_i;
    flags_o  = flags_i;
    acts_o   = '0;
    hold_inc = state_i.hold;
    rel_inc  = state_i.rel;

    if (edge_i) begin
      if (!state_i.busy && down_i) begin
        state_o.busy      = 1'b1;
        state_o.hold      = '0;
        state_o.rel       = '0;
        state_o.long_done = 1'b0;
        state_o.consumed  = alarm_edge_i;
        acts_o.feedback   = 1'b1;
        acts_o.wake       = 1'b1;
        acts_o.ack        = alarm_edge_i;
      end
    end else if (tick_i && state_i.busy) begin
      if (down_i) begin
        state_o.rel = '0;
        if (!state_i.long_done && !state_i.consumed) begin
          if (state_i.hold < long_press_i) begin
            hold_inc = state_i.hold + HoldW'(1);
          end
          state_o.hold = hold_inc;
          if (hold_inc >= long_press_i) begin
            state_o.long_done = 1'b1;
            if (flags_i.settings) begin
              acts_o.exitm     = 1'b1;
              acts_o.refresh   = 1'b1;
              acts_o.wake      = 1'b1;
              flags_o.settings = 1'b0;
            end else if (is_one_i && !other_down_i && !flags_i.alarm) begin
              acts_o.enter     = 1'b1;
              acts_o.wake      = 1'b1;
              flags_o.settings = 1'b1;
            end
          end
        end
      end else begin
        if (state_i.rel < release_i) begin
          rel_inc = state_i.rel + RelW'(1);
        end
        state_o.rel = rel_inc;
        if (rel_inc >= release_i) begin
          if (!state_i.long_done && !state_i.consumed) begin
            if (flags_i.alarm) begin
              acts_o.ack    = 1'b1;
              acts_o.wake   = 1'b1;
              flags_o.alarm = 1'b0;
            end else if (flags_i.settings) begin
              if (is_one_i) begin
                acts_o.select = 1'b1;
              end else begin
                acts_o.next = 1'b1;
                acts_o.wake = 1'b1;
              end
            end else if (!is_one_i) begin
              acts_o.toggle  = 1'b1;
              acts_o.refresh = 1'b1;
              acts_o.wake    = 1'b1;
            end
          end
          state_o.busy = 1'b0;
          state_o.hold = '0;
          state_o.rel  = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/two_button_press_classifier.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier: short/long press qualification for two buttons
// Input register, one pass of button logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one
//   transaction per button falling edge or debounce tick, with both button
//   levels and the alarm and settings flags. Every input transaction yields
//   exactly one output transaction (out_valid_o / out_stall_i / out_item_o).
//   An accepted transaction waits in the input register, then passes through
//   the button logic into the result register and so to out_valid_o.
//   Throughput is one transaction per cycle while the receiver does not
//   stall, as the button state updates combinationally between the registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register takes one more; after that in_stall_o is raised until
//   the result is taken. No transaction is lost or repeated.
//   The configuration channel (cfg_valid_i / cfg_ready_o) is always ready;
//   index 0 is the long-press threshold, index 1 the release threshold.
//   Write it only while no transaction is in flight.
//   Reset clears all button state, selects Celsius and loads thresholds of
//   50 hold ticks and 2 release ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_press_classifier import tbpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [HoldW-1:0] long_press_q;
  logic [RelW-1:0]  release_q;

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q, out_item_d;

  btn_state_t one_q, one_d, two_q, two_d;
  logic       fahr_q, fahr_d;

  logic       advance;
  logic       edge_one, edge_two, tick;
  flags_t     flags_in, flags_mid, flags_end;
  acts_t      acts_one, acts_two, acts;

  // result register frees up when empty or being taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      release_q    <= ReleaseReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_PRESS: long_press_q <= cfg_data_i[HoldW-1:0];
        CFG_RELEASE:    release_q    <= cfg_data_i[RelW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // op decode; unknown op drives none of these
  always_comb begin
    edge_one = 1'b0;
    edge_two = 1'b0;
    tick     = 1'b0;
    case (in_item_q.op)
      OP_ONE_EDGE: edge_one = 1'b1;
      OP_TWO_EDGE: edge_two = 1'b1;
      OP_TICK:     tick     = 1'b1;
      default: ;
    endcase
  end

  assign flags_in.alarm    = in_item_q.alarm_active;
  assign flags_in.settings = in_item_q.settings_active;

  // button one runs first; button two sees the flags it leaves
  tbpc_button u_one (
    .is_one_i     (1'b1),
    .edge_i       (edge_one),
    .tick_i       (tick),
    .down_i       (in_item_q.one_down),
    .other_down_i (in_item_q.two_down),
    .alarm_edge_i (in_item_q.alarm_active),
    .flags_i      (flags_in),
    .long_press_i (long_press_q),
    .release_i    (release_q),
    .state_i      (one_q),
    .state_o      (one_d),
    .flags_o      (flags_mid),
    .acts_o       (acts_one)
  );

  tbpc_button u_two (
    .is_one_i     (1'b0),
    .edge_i       (edge_two),
    .tick_i       (tick),
    .down_i       (in_item_q.two_down),
    .other_down_i (in_item_q.one_down),
    .alarm_edge_i (in_item_q.alarm_active),
    .flags_i      (flags_mid),
    .long_press_i (long_press_q),
    .release_i    (release_q),
    .state_i      (two_q),
    .state_o      (two_d),
    .flags_o      (flags_end),
    .acts_o       (acts_two)
  );

  assign acts   = acts_one | acts_two;
  assign fahr_d = fahr_q ^ acts.toggle;

  always_comb begin
    out_item_d.start_feedback     = acts.feedback;
    out_item_d.ack_alarm          = acts.ack;
    out_item_d.enter_settings     = acts.enter;
    out_item_d.exit_settings      = acts.exitm;
    out_item_d.select_option      = acts.select;
    out_item_d.next_option        = acts.next;
    out_item_d.refresh_display    = acts.refresh;
    out_item_d.unit_is_fahrenheit = fahr_d;
    out_item_d.wake               = acts.wake;
    // final flags only feed the chain; idle comes from the new busy bits
    out_item_d.idle               = !one_d.busy && !two_d.busy &&
                                    (flags_end == flags_end);
  end

  // button state commits when the transaction moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q  <= '0;
      two_q  <= '0;
      fahr_q <= 1'b0;
    end else if (advance) begin
      one_q  <= one_d;
      two_q  <= two_d;
      fahr_q <= fahr_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: tb/press_action_checker.sv
// ----------------------------------------------------------------------------
// press_action_checker: scoreboard for the two-button press classifier
// Follows the input and configuration channels with a cycle-free model of the
// press logic, queues the predicted action flags and compares every output
// transaction against the oldest prediction, flag by flag.
// ----------------------------------------------------------------------------
module press_action_checker import tbpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int unsigned MaxPrinted = 40;

  // model state: index 0 is button one, index 1 button two
  btn_state_t       press_q [2];
  logic [HoldW-1:0] long_thr_q;
  logic [RelW-1:0]  rel_thr_q;
  logic             unit_f_q;

  out_item_t expected_actions_q [$];
  out_item_t want_q;
  int        fault_cnt = 0;
  int        results_seen = 0;

  assign errors_o = fault_cnt;

  task automatic flag_error(string what);
    if (fault_cnt < MaxPrinted)
      $display("[%0t] ERROR result %0d: %s", $time, results_seen, what);
    fault_cnt = fault_cnt + 1;
  endtask

  task automatic compare_flag(string name, logic got, logic want);
    if (got !== want)
      flag_error($sformatf("%s is %b, expected %b", name, got, want));
  endtask

  // Advances the press state by one transaction and returns its action flags.
  // Within a tick button two sees alarm/settings as button one left them.
  function automatic out_item_t classify_press(in_item_t it);
    acts_t     act;
    flags_t    fl;
    logic      down;
    logic      other;
    int        b;
    out_item_t r;
    act         = '0;
    fl.alarm    = it.alarm_active;
    fl.settings = it.settings_active;
    case (it.op)
      OP_ONE_EDGE, OP_TWO_EDGE: begin
        b    = (it.op == OP_TWO_EDGE) ? 1 : 0;
        down = (b == 0) ? it.one_down : it.two_down;
        if (!press_q[b].busy && down) begin
          press_q[b]      = '0;
          press_q[b].busy = 1'b1;
          act.feedback    = 1'b1;
          act.wake        = 1'b1;
          if (fl.alarm) begin
            act.ack             = 1'b1;
            press_q[b].consumed = 1'b1;
          end
        end
      end
      OP_TICK: begin
        for (b = 0; b < 2; b++) begin
          down  = (b == 0) ? it.one_down : it.two_down;
          other = (b == 0) ? it.two_down : it.one_down;
          if (press_q[b].busy) begin
            if (down) begin
              press_q[b].rel = '0;
              if (!press_q[b].long_done && !press_q[b].consumed) begin
                if (press_q[b].hold < long_thr_q)
                  press_q[b].hold = press_q[b].hold + 1'b1;
                if (press_q[b].hold >= long_thr_q) begin
                  press_q[b].long_done = 1'b1;
                  if (fl.settings) begin
                    act.exitm   = 1'b1;
                    act.refresh = 1'b1;
                    act.wake    = 1'b1;
                    fl.settings = 1'b0;
                  end else if (b == 0 && !other && !fl.alarm) begin
                    act.enter   = 1'b1;
                    act.wake    = 1'b1;
                    fl.settings = 1'b1;
                  end
                end
              end
            end else begin
              if (press_q[b].rel < rel_thr_q)
                press_q[b].rel = press_q[b].rel + 1'b1;
              if (press_q[b].rel >= rel_thr_q) begin
                if (!press_q[b].long_done && !press_q[b].consumed) begin
                  if (fl.alarm) begin
                    act.ack  = 1'b1;
                    act.wake = 1'b1;
                    fl.alarm = 1'b0;
                  end else if (fl.settings) begin
                    if (b == 0) begin
                      act.select = 1'b1;
                    end else begin
                      act.next = 1'b1;
                      act.wake = 1'b1;
                    end
                  end else if (b == 1) begin
                    unit_f_q    = !unit_f_q;
                    act.refresh = 1'b1;
                    act.wake    = 1'b1;
                  end
                end
                press_q[b].busy = 1'b0;
                press_q[b].hold = '0;
                press_q[b].rel  = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.start_feedback     = act.feedback;
    r.ack_alarm          = act.ack;
    r.enter_settings     = act.enter;
    r.exit_settings      = act.exitm;
    r.select_option      = act.select;
    r.next_option        = act.next;
    r.refresh_display    = act.refresh;
    r.unit_is_fahrenheit = unit_f_q;
    r.wake               = act.wake;
    r.idle               = !press_q[0].busy && !press_q[1].busy;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q[0]   = '0;
      press_q[1]   = '0;
      unit_f_q     = 1'b0;
      long_thr_q   = LongPressReset;
      rel_thr_q    = ReleaseReset;
      results_seen = 0;
      expected_actions_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LONG_PRESS: long_thr_q = cfg_data_i[HoldW-1:0];
          CFG_RELEASE:    rel_thr_q  = cfg_data_i[RelW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen = results_seen + 1;
        if (expected_actions_q.size() == 0) begin
          flag_error("output transaction with nothing outstanding");
        end else begin
          want_q = expected_actions_q.pop_front();
          compare_flag("start_feedback", out_item_i.start_feedback, want_q.start_feedback);
          compare_flag("ack_alarm", out_item_i.ack_alarm, want_q.ack_alarm);
          compare_flag("enter_settings", out_item_i.enter_settings, want_q.enter_settings);
          compare_flag("exit_settings", out_item_i.exit_settings, want_q.exit_settings);
          compare_flag("select_option", out_item_i.select_option, want_q.select_option);
          compare_flag("next_option", out_item_i.next_option, want_q.next_option);
          compare_flag("refresh_display", out_item_i.refresh_display,
                       want_q.refresh_display);
          compare_flag("unit_is_fahrenheit", out_item_i.unit_is_fahrenheit,
                       want_q.unit_is_fahrenheit);
          compare_flag("wake", out_item_i.wake, want_q.wake);
          compare_flag("idle", out_item_i.idle, want_q.idle);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_actions_q.push_back(classify_press(in_item_i));
      pending_o <= expected_actions_q.size();
    end
  end

endmodule

FILE: tb/two_button_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier_tb: top-level bench for the press classifier
// Drives button edges and debounce ticks through a directed opening and then
// randomised press sequences under several threshold settings, with random
// gaps and receiver stalls; a side checker predicts and compares the flags.
// ----------------------------------------------------------------------------
module two_button_press_classifier_tb;
  import tbpc_pkg::*;

  // op value outside the defined set; the block must treat it as a no-op
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int CycleLimit    = 1000000;
  localparam int BacklogCycles = 300;
  localparam int PhaseItems    = 45;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  // sender side
  logic                in_valid = 1'b0;
  in_item_t            in_item = '0;
  logic                in_stall;

  // receiver side
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;

  // configuration channel
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_LONG_PRESS;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                cfg_ready;

  int pending;
  int errors;

  // stimulus bookkeeping
  int   items_sent = 0;
  int   backlog_asked = 0;
  logic sender_calm = 1'b0;
  int   long_cur = int'(LongPressReset);
  int   rel_cur = int'(ReleaseReset);

  always #5 clk_i = ~clk_i;

  two_button_press_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  press_action_checker press_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Idle spacing shared by both sides: mostly back-to-back, some short
  // gaps, the odd long one. A calm caller never idles.
  function automatic int pick_gap(logic calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Hold length for a random press: usually short, a quarter of the time
  // anywhere up to just past the long-press threshold.
  function automatic int pick_hold();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, long_cur + 2);
    return $urandom_range(0, 5);
  endfunction

  // Offers one input transaction and returns at the edge that takes it.
  // Valid stays high into the next call so back-to-back offers never dip.
  task automatic offer(logic [1:0] op, logic one_dn, logic two_dn, logic alarm,
                       logic menu);
    in_item_t it;
    int       gap;
    it.op              = op;
    it.one_down        = one_dn;
    it.two_down        = two_dn;
    it.alarm_active    = alarm;
    it.settings_active = menu;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    items_sent = items_sent + 1;
  endtask

  // Stops offering and waits until every prediction has been matched.
  // The first edge lets the checker's count catch up with the last push.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Both thresholds are written back to back, only with the block empty.
  task automatic program_thresholds(logic [CfgDataW-1:0] long_data,
                                    logic [CfgDataW-1:0] rel_data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= long_data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_RELEASE;
    cfg_data  <= rel_data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    long_cur = int'(long_data[HoldW-1:0]);
    rel_cur  = int'(rel_data[RelW-1:0]);
  endtask

  // One well-formed press sequence: falling edges for the armed buttons,
  // then ticks holding each for its own time and releasing long enough to
  // finish. Levels bounce now and then and the flags occasionally flip.
  task automatic press_episode();
    int   which;
    int   h1;
    int   h2;
    int   span;
    int   t;
    logic a1;
    logic a2;
    logic first_two;
    logic alarm_lvl;
    logic menu_lvl;
    logic d1;
    logic d2;
    logic al;
    logic mn;
    which     = $urandom_range(0, 3);
    a1        = (which != 1);
    a2        = (which != 0);
    h1        = pick_hold();
    h2        = pick_hold();
    first_two = 1'($urandom_range(0, 1));
    alarm_lvl = ($urandom_range(0, 3) == 0);
    menu_lvl  = 1'($urandom_range(0, 1));
    if (a2 && first_two)
      offer(OP_TWO_EDGE, 1'b0, 1'b1, $urandom_range(0, 3) == 0, menu_lvl);
    if (a1)
      offer(OP_ONE_EDGE, 1'b1, a2 && first_two && h2 > 0,
            $urandom_range(0, 3) == 0, menu_lvl);
    if (a2 && !first_two)
      offer(OP_TWO_EDGE, a1 && h1 > 0, 1'b1, $urandom_range(0, 3) == 0, menu_lvl);
    span = ((h1 > h2) ? h1 : h2) + rel_cur + 1 + $urandom_range(0, 2);
    for (t = 0; t < span; t++) begin
      d1 = a1 ? (t < h1) : ($urandom_range(0, 3) == 0);
      d2 = a2 ? (t < h2) : ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) d1 = !d1;
      if ($urandom_range(0, 15) == 0) d2 = !d2;
      al = ($urandom_range(0, 9) == 0) ? !alarm_lvl : alarm_lvl;
      mn = ($urandom_range(0, 9) == 0) ? !menu_lvl : menu_lvl;
      offer(OP_TICK, d1, d2, al, mn);
    end
  endtask

  // A random phase under one threshold setting; mostly press sequences,
  // about one in five draws is a single noise transaction. With squeeze set the
  // receiver holds off for a long stretch while offers keep coming.
  task automatic random_phase(logic [CfgDataW-1:0] long_data,
                              logic [CfgDataW-1:0] rel_data, logic squeeze);
    int phase_start;
    program_thresholds(long_data, rel_data);
    if (squeeze) begin
      backlog_asked = backlog_asked + 1;
      sender_calm   = 1'b1;
    end
    phase_start = items_sent;
    while (items_sent - phase_start < PhaseItems) begin
      if ($urandom_range(0, 4) == 0)
        offer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
      else
        press_episode();
      sender_calm = ($urandom_range(0, 5) == 0);
    end
  endtask

  // Receiver: runs of acceptance, random stalls, and on request one long
  // hold-off counted here in cycles.
  initial begin : result_sink
    int span;
    int served;
    served = 0;
    forever begin
      if (served != backlog_asked) begin
        served = served + 1;
        out_stall <= 1'b1;
        repeat (BacklogCycles) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                           : $urandom_range(1, 12);
        repeat (span) @(posedge clk_i);
        span = pick_gap(1'b0);
        if (span > 0) begin
          out_stall <= 1'b1;
          repeat (span) @(posedge clk_i);
        end
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles = cycles + 1;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed opening, reset thresholds (long 50, release 2) ---
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);       // tick with nothing armed
    offer(OP_SPARE, 1'b1, 1'b1, 1'b1, 1'b1);      // undefined op: no action
    offer(OP_ONE_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);   // edge while released: ignored
    offer(OP_ONE_EDGE, 1'b1, 1'b0, 1'b1, 1'b0);   // arms and acks the alarm
    offer(OP_ONE_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);   // already busy: ignored
    offer(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1);       // consumed press does not count
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);       // ends silently
    offer(OP_TWO_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);       // short press on two: unit flips
    offer(OP_ONE_EDGE, 1'b1, 1'b0, 1'b0, 1'b1);
    offer(OP_TWO_EDGE, 1'b1, 1'b1, 1'b0, 1'b1);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);       // select and next in one tick
    offer(OP_ONE_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(OP_TWO_EDGE, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0);       // one acks, two sees alarm gone

    // --- long presses with short thresholds ---
    program_thresholds(10'd2, 10'd1);
    offer(OP_ONE_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0);       // long on one: enter settings
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);       // release after long: silent
    offer(OP_TWO_EDGE, 1'b0, 1'b1, 1'b0, 1'b1);
    offer(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b1);
    offer(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b1);       // long on two in settings: exit
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);

    // --- zero thresholds: long on first held tick, end on first release ---
    program_thresholds(10'd0, 10'd0);
    offer(OP_ONE_EDGE, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);

    // --- random phases; upper bits of the release write must be dropped ---
    random_phase(10'd50, 10'd2, 1'b0);
    random_phase(10'd1, 10'd1, 1'b1);
    random_phase(10'd0, 10'd0, 1'b0);
    random_phase(10'd6, 10'd3, 1'b0);
    random_phase(10'd3, 10'h301, 1'b0);
    random_phase(10'd12, 10'd4, 1'b0);

    // --- top thresholds: short press on two, then a full release count ---
    program_thresholds(10'h3FF, 10'h0FF);
    sender_calm = 1'b1;
    offer(OP_TWO_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    repeat (6) offer(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
    repeat (256) offer(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
